// ===== sv/assert_macros.svh =====
// assertion macros shared by the lexer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on clk, off during rst
`define CDL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, clocked on clk, off during rst
`define CDL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CDL_ASSERT_NOW(lbl, ante, cons, msg)
`define CDL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/cdl_pkg.sv =====
// types and constants of the character class lexer
`timescale 1ns / 1ps
`default_nettype none
package cdl_pkg;

  // default sizes of the automaton
  localparam int DEF_STATES = 16;
  localparam int DEF_RULES  = 8;

  // fixed field widths
  localparam int FUNC_W  = 3;
  localparam int STATE_W = 4;
  localparam int RULE_W  = 3;
  localparam int WORD_W  = 2;
  localparam int CLASS_W = 64;
  localparam int TOKEN_W = 8;
  localparam int CHAR_W  = 8;

  // item function codes
  typedef enum logic [FUNC_W-1:0] {
    FN_CLASS   = 3'd0,
    FN_RULE    = 3'd1,
    FN_ATTR    = 3'd2,
    FN_RESTART = 3'd3,
    FN_CHAR    = 3'd4
  } func_t;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_ATTR,
    ST_DONE
  } ctl_state_t;

  // one rule slot
  typedef struct packed {
    logic               used;
    logic               invert;
    logic [STATE_W-1:0] target;
  } rule_t;

  // per-state attributes
  typedef struct packed {
    logic               is_final;
    logic [TOKEN_W-1:0] token;
  } attr_t;

  // one result word
  typedef struct packed {
    logic               dead;
    logic [STATE_W-1:0] next_state;
    logic               accepting;
    logic [TOKEN_W-1:0] token_res;
  } result_t;

  // controller status seen by the top level
  typedef struct packed {
    logic clearing;
    logic busy;
  } ctl_status_t;

endpackage
`default_nettype wire

// ===== sv/cdl_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module cdl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/cdl_ctrl.sv =====
// lexer controller: clearing pass, load writes, rule scan and result register
`timescale 1ns / 1ps
`default_nettype none
module cdl_ctrl #(
  parameter int STATES          = cdl_pkg::DEF_STATES,
  parameter int RULES_PER_STATE = cdl_pkg::DEF_RULES,
  localparam int SW   = $clog2(STATES),
  localparam int DR   = STATES * RULES_PER_STATE,
  localparam int AWR  = (DR > 1) ? $clog2(DR) : 1,
  localparam int AWC  = AWR + cdl_pkg::WORD_W
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [cdl_pkg::FUNC_W-1:0]     func,
  input  wire logic [cdl_pkg::STATE_W-1:0]    state_index,
  input  wire logic [cdl_pkg::RULE_W-1:0]     rule_index,
  input  wire logic [cdl_pkg::WORD_W-1:0]     word_index,
  input  wire logic [cdl_pkg::CLASS_W-1:0]    class_word,
  input  wire logic [cdl_pkg::STATE_W-1:0]    target_state,
  input  wire logic                           invert,
  input  wire logic                           rule_used,
  input  wire logic                           is_final,
  input  wire logic [cdl_pkg::TOKEN_W-1:0]    token,
  input  wire logic [cdl_pkg::CHAR_W-1:0]     character,
  // output channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output cdl_pkg::result_t                    out_res,
  output cdl_pkg::ctl_status_t                status,
  // rule memory
  output logic                                rule_we,
  output logic [AWR-1:0]                      rule_waddr,
  output logic [$bits(cdl_pkg::rule_t)-1:0]   rule_wdata,
  output logic [AWR-1:0]                      rule_raddr,
  input  wire logic [$bits(cdl_pkg::rule_t)-1:0] rule_rdata,
  // class memory
  output logic                                class_we,
  output logic [AWC-1:0]                      class_waddr,
  output logic [cdl_pkg::CLASS_W-1:0]         class_wdata,
  output logic [AWC-1:0]                      class_raddr,
  input  wire logic [cdl_pkg::CLASS_W-1:0]    class_rdata,
  // state attribute memory
  output logic                                attr_we,
  output logic [SW-1:0]                       attr_waddr,
  output logic [$bits(cdl_pkg::attr_t)-1:0]   attr_wdata,
  output logic [SW-1:0]                       attr_raddr,
  input  wire logic [$bits(cdl_pkg::attr_t)-1:0] attr_rdata
);

  localparam int IW = $clog2(RULES_PER_STATE + 1);

  cdl_pkg::ctl_state_t st, st_next;
  logic [SW-1:0]                cur, cur_next;
  logic                         dead_flag, dead_flag_next;
  logic [AWR-1:0]               clr, clr_next;
  logic [IW-1:0]                iss, iss_next;
  logic                         chk, chk_next;
  logic                         chk_last, chk_last_next;
  logic [cdl_pkg::CHAR_W-1:0]   chr, chr_next;
  cdl_pkg::result_t             res, res_next;
  cdl_pkg::result_t             out_res_next;
  logic                         out_valid_next;

  logic                         st_ok;
  logic                         slot_ok;
  logic [AWR-1:0]               slot_in;
  logic                         issue;
  logic                         hit;
  cdl_pkg::rule_t               rl;
  cdl_pkg::attr_t               at;

  // range checks and load address
  assign st_ok   = 32'(state_index) < 32'(STATES);
  assign slot_ok = st_ok && (32'(rule_index) < 32'(RULES_PER_STATE));
  assign slot_in = AWR'(32'(state_index) * 32'(RULES_PER_STATE) + 32'(rule_index));

  // scan read side
  assign issue = 32'(iss) < 32'(RULES_PER_STATE);
  assign rl    = cdl_pkg::rule_t'(rule_rdata);
  assign at    = cdl_pkg::attr_t'(attr_rdata);
  assign hit   = class_rdata[chr[5:0]];

  assign rule_raddr  = AWR'(32'(cur) * 32'(RULES_PER_STATE) + 32'(iss));
  assign class_raddr = {rule_raddr, chr[7:6]};
  assign class_waddr = {slot_in, word_index};
  assign class_wdata = class_word;

  assign in_stall        = (st != cdl_pkg::ST_IDLE);
  assign status.clearing = (st == cdl_pkg::ST_CLEAR);
  assign status.busy     = (st != cdl_pkg::ST_IDLE);

  // state and work registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= cdl_pkg::ST_CLEAR;
      cur       <= '0;
      dead_flag <= 1'b0;
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      st        <= st_next;
      cur       <= cur_next;
      dead_flag <= dead_flag_next;
      clr       <= clr_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    iss      <= iss_next;
    chk      <= chk_next;
    chk_last <= chk_last_next;
    chr      <= chr_next;
    res      <= res_next;
    out_res  <= out_res_next;
  end

  // next state and memory control
  always_comb begin
    st_next        = st;
    cur_next       = cur;
    dead_flag_next = dead_flag;
    clr_next       = clr;
    iss_next       = iss;
    chk_next       = chk;
    chk_last_next  = chk_last;
    chr_next       = chr;
    res_next       = res;
    out_res_next   = out_res;
    out_valid_next = out_valid && out_stall;

    rule_we    = 1'b0;
    rule_waddr = slot_in;
    rule_wdata = {rule_used, invert, target_state};
    class_we   = 1'b0;
    attr_we    = 1'b0;
    attr_waddr = SW'(state_index);
    attr_wdata = {is_final, token};
    attr_raddr = SW'(state_index);

    unique case (st)
      cdl_pkg::ST_CLEAR: begin
        // sweep rule and attribute stores to zero
        rule_we    = 1'b1;
        rule_waddr = clr;
        rule_wdata = '0;
        attr_we    = 32'(clr) < 32'(STATES);
        attr_waddr = SW'(clr);
        attr_wdata = '0;
        clr_next   = clr + AWR'(1);
        if (clr == AWR'(DR - 1)) begin
          st_next = cdl_pkg::ST_IDLE;
        end
      end
      cdl_pkg::ST_IDLE: begin
        if (in_valid) begin
          res_next = '0;
          st_next  = cdl_pkg::ST_DONE;
          unique case (cdl_pkg::func_t'(func))
            cdl_pkg::FN_CLASS: begin
              class_we = slot_ok;
            end
            cdl_pkg::FN_RULE: begin
              rule_we = slot_ok;
            end
            cdl_pkg::FN_ATTR: begin
              attr_we = st_ok;
            end
            cdl_pkg::FN_RESTART: begin
              if (st_ok) begin
                cur_next            = SW'(state_index);
                dead_flag_next      = 1'b0;
                res_next.next_state = state_index;
                st_next             = cdl_pkg::ST_ATTR;
              end
            end
            cdl_pkg::FN_CHAR: begin
              if (dead_flag) begin
                res_next.dead = 1'b1;
              end else begin
                chr_next = character;
                iss_next = '0;
                chk_next = 1'b0;
                st_next  = cdl_pkg::ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      cdl_pkg::ST_SCAN: begin
        // issue the next rule read, check the one read last cycle
        chk_next      = issue;
        chk_last_next = 32'(iss) == 32'(RULES_PER_STATE - 1);
        if (issue) begin
          iss_next = iss + IW'(1);
        end
        if (chk && rl.used && (hit != rl.invert)) begin
          if (32'(rl.target) < 32'(STATES)) begin
            cur_next            = SW'(rl.target);
            res_next.next_state = rl.target;
            attr_raddr          = SW'(rl.target);
            st_next             = cdl_pkg::ST_ATTR;
          end else begin
            dead_flag_next = 1'b1;
            res_next.dead  = 1'b1;
            st_next        = cdl_pkg::ST_DONE;
          end
        end else if (chk && chk_last) begin
          dead_flag_next = 1'b1;
          res_next.dead  = 1'b1;
          st_next        = cdl_pkg::ST_DONE;
        end
      end
      cdl_pkg::ST_ATTR: begin
        // attributes of the new state are on the read port
        res_next.accepting = at.is_final;
        res_next.token_res = at.token;
        st_next            = cdl_pkg::ST_DONE;
      end
      cdl_pkg::ST_DONE: begin
        // hand the word to the output register once it is free
        if (!out_valid || !out_stall) begin
          out_res_next   = res;
          out_valid_next = 1'b1;
          st_next        = cdl_pkg::ST_IDLE;
        end
      end
      default: begin
        st_next = cdl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/char_class_dfa_lexer.sv =====
// top level of the programmable character class lexer automaton
//
//   channel | direction | handshake            | words
//   in      | in        | in_valid / in_stall  | load, restart or character item
//   out     | out       | out_valid / out_stall| one result per item
//
// after reset a clearing pass over all STATES*RULES_PER_STATE rule slots (128 by default)
// zeroes the rule and attribute stores; in_stall stays high until it ends.
// load items go through ST_DONE, restart through ST_ATTR and ST_DONE; a character
// item is scanned in ST_SCAN by the single rule memory read port, which checks
// one rule per cycle in priority order. one item is worked on at a time; the
// next is taken while a finished word waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module char_class_dfa_lexer #(
  parameter int STATES          = cdl_pkg::DEF_STATES,
  parameter int RULES_PER_STATE = cdl_pkg::DEF_RULES
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [cdl_pkg::FUNC_W-1:0]  func,
  input  wire logic [cdl_pkg::STATE_W-1:0] state_index,
  input  wire logic [cdl_pkg::RULE_W-1:0]  rule_index,
  input  wire logic [cdl_pkg::WORD_W-1:0]  word_index,
  input  wire logic [cdl_pkg::CLASS_W-1:0] class_word,
  input  wire logic [cdl_pkg::STATE_W-1:0] target_state,
  input  wire logic                        invert,
  input  wire logic                        rule_used,
  input  wire logic                        is_final,
  input  wire logic [cdl_pkg::TOKEN_W-1:0] token,
  input  wire logic [cdl_pkg::CHAR_W-1:0]  character,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             dead,
  output logic [cdl_pkg::STATE_W-1:0]      next_state,
  output logic                             accepting,
  output logic [cdl_pkg::TOKEN_W-1:0]      token_res
);

  localparam int SW  = $clog2(STATES);
  localparam int DR  = STATES * RULES_PER_STATE;
  localparam int AWR = (DR > 1) ? $clog2(DR) : 1;
  localparam int AWC = AWR + cdl_pkg::WORD_W;
  localparam int RBW = $bits(cdl_pkg::rule_t);
  localparam int ABW = $bits(cdl_pkg::attr_t);

  cdl_pkg::result_t     out_res;
  cdl_pkg::ctl_status_t status;

  logic                         rule_we;
  logic [AWR-1:0]               rule_waddr, rule_raddr;
  logic [RBW-1:0]               rule_wdata, rule_rdata;
  logic                         class_we;
  logic [AWC-1:0]               class_waddr, class_raddr;
  logic [cdl_pkg::CLASS_W-1:0]  class_wdata, class_rdata;
  logic                         attr_we;
  logic [SW-1:0]                attr_waddr, attr_raddr;
  logic [ABW-1:0]               attr_wdata, attr_rdata;
  logic                         dead_data;

  // controller
  cdl_ctrl #(
    .STATES          (STATES),
    .RULES_PER_STATE (RULES_PER_STATE)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .state_index  (state_index),
    .rule_index   (rule_index),
    .word_index   (word_index),
    .class_word   (class_word),
    .target_state (target_state),
    .invert       (invert),
    .rule_used    (rule_used),
    .is_final     (is_final),
    .token        (token),
    .character    (character),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_res      (out_res),
    .status       (status),
    .rule_we      (rule_we),
    .rule_waddr   (rule_waddr),
    .rule_wdata   (rule_wdata),
    .rule_raddr   (rule_raddr),
    .rule_rdata   (rule_rdata),
    .class_we     (class_we),
    .class_waddr  (class_waddr),
    .class_wdata  (class_wdata),
    .class_raddr  (class_raddr),
    .class_rdata  (class_rdata),
    .attr_we      (attr_we),
    .attr_waddr   (attr_waddr),
    .attr_wdata   (attr_wdata),
    .attr_raddr   (attr_raddr),
    .attr_rdata   (attr_rdata)
  );

  // rule slots: used, invert, target
  cdl_ram #(
    .WIDTH (RBW),
    .DEPTH (DR)
  ) u_rule_ram (
    .clk   (clk),
    .we    (rule_we),
    .waddr (rule_waddr),
    .wdata (rule_wdata),
    .raddr (rule_raddr),
    .rdata (rule_rdata)
  );

  // class bitmaps, four words per rule slot
  cdl_ram #(
    .WIDTH (cdl_pkg::CLASS_W),
    .DEPTH (DR * 4)
  ) u_class_ram (
    .clk   (clk),
    .we    (class_we),
    .waddr (class_waddr),
    .wdata (class_wdata),
    .raddr (class_raddr),
    .rdata (class_rdata)
  );

  // state attributes: final flag and token
  cdl_ram #(
    .WIDTH (ABW),
    .DEPTH (STATES)
  ) u_attr_ram (
    .clk   (clk),
    .we    (attr_we),
    .waddr (attr_waddr),
    .wdata (attr_wdata),
    .raddr (attr_raddr),
    .rdata (attr_rdata)
  );

  // result word onto the ports
  assign dead       = out_res.dead;
  assign next_state = out_res.next_state;
  assign accepting  = out_res.accepting;
  assign token_res  = out_res.token_res;

  // any state data on the result ports
  assign dead_data = |{next_state, accepting, token_res};

  // checks
  `CDL_ASSERT_NOW(a_dead_zero, out_valid && dead, !dead_data, "dead word carries state data")
  `CDL_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "second word taken while busy")
  `CDL_ASSERT_NOW(a_clear_blocks, status.clearing, in_stall, "word taken during clearing pass")
  `CDL_ASSERT_NOW(a_busy_stalls, status.busy, in_stall, "word taken while controller busy")

endmodule
`default_nettype wire

// ===== sim/lexer_checker.sv =====
// channel monitor, lexer prediction and result comparison for the lexer bench
`timescale 1ns / 1ps
module lexer_checker
  import cdl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [FUNC_W-1:0]  func,
  input  wire logic [STATE_W-1:0] state_index,
  input  wire logic [RULE_W-1:0]  rule_index,
  input  wire logic [WORD_W-1:0]  word_index,
  input  wire logic [CLASS_W-1:0] class_word,
  input  wire logic [STATE_W-1:0] target_state,
  input  wire logic               invert,
  input  wire logic               rule_used,
  input  wire logic               is_final,
  input  wire logic [TOKEN_W-1:0] token,
  input  wire logic [CHAR_W-1:0]  character,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic               dead,
  input  wire logic [STATE_W-1:0] next_state,
  input  wire logic               accepting,
  input  wire logic [TOKEN_W-1:0] token_res,
  output int                      errors,
  output int                      pending,
  output int                      n_words,
  output int                      n_dead,
  output int                      n_accepting
);

  localparam int SLOTS = DEF_STATES * DEF_RULES;

  // shadow of the automaton tables and position
  rule_t              rule_mem  [SLOTS];
  attr_t              attr_mem  [DEF_STATES];
  logic [CLASS_W-1:0] class_mem [SLOTS*4];
  logic [STATE_W-1:0] lex_state;
  logic               lex_dead;

  // result words still owed by the block, oldest first
  result_t due_results [$];

  task automatic report(string field, logic [7:0] got, logic [7:0] want);
    $display("lexer_checker: word %0d %s got %0h expected %0h", n_words, field, got, want);
    errors++;
  endtask

  function automatic result_t state_word(logic [STATE_W-1:0] s);
    result_t res;
    res            = '0;
    res.next_state = s;
    res.accepting  = attr_mem[s].is_final;
    res.token_res  = attr_mem[s].token;
    return res;
  endfunction

  // apply one accepted input word to the shadow and queue its result
  task automatic lex_step();
    result_t res;
    rule_t   rl;
    int      slot;
    int      base;
    logic    fired;
    logic    hit;
    res  = '0;
    slot = int'(state_index) * DEF_RULES + int'(rule_index);
    case (func)
      FN_CLASS: class_mem[slot*4 + int'(word_index)] = class_word;
      FN_RULE: rule_mem[slot] = rule_t'({rule_used, invert, target_state});
      FN_ATTR: attr_mem[state_index] = attr_t'({is_final, token});
      FN_RESTART: begin
        lex_state = state_index;
        lex_dead  = 1'b0;
        res       = state_word(lex_state);
      end
      FN_CHAR: begin
        // first used rule in slot order whose class test differs from its invert bit
        if (!lex_dead) begin
          fired = 1'b0;
          base  = int'(lex_state) * DEF_RULES;
          for (int r = 0; r < DEF_RULES; r++) begin
            rl = rule_mem[base + r];
            if (!fired && rl.used) begin
              hit = class_mem[(base + r)*4 + int'(character[7:6])][character[5:0]];
              if (hit != rl.invert) begin
                fired     = 1'b1;
                lex_state = rl.target;
              end
            end
          end
          if (!fired) lex_dead = 1'b1;
        end
        if (lex_dead) res.dead = 1'b1;
        else res = state_word(lex_state);
      end
      default: ;
    endcase
    due_results = {due_results, res};
  endtask

  // compare one accepted result word with the oldest owed one
  task automatic check_word();
    result_t want;
    if (due_results.size() == 0) begin
      report("unexpected word", 8'd1, 8'd0);
      return;
    end
    want = due_results.pop_front();
    n_words++;
    if (want.dead) n_dead++;
    if (want.accepting) n_accepting++;
    if (dead !== want.dead) report("dead", 8'(dead), 8'(want.dead));
    if (next_state !== want.next_state) report("next_state", 8'(next_state), 8'(want.next_state));
    if (accepting !== want.accepting) report("accepting", 8'(accepting), 8'(want.accepting));
    if (token_res !== want.token_res) report("token_res", token_res, want.token_res);
  endtask

  // watch both channels
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) rule_mem[i] = '0;
      for (int i = 0; i < SLOTS*4; i++) class_mem[i] = '0;
      for (int i = 0; i < DEF_STATES; i++) attr_mem[i] = '0;
      lex_state = '0;
      lex_dead  = 1'b0;
      due_results.delete();
      errors      = 0;
      n_words     = 0;
      n_dead      = 0;
      n_accepting = 0;
      pending <= 0;
    end else begin
      if (in_valid && !in_stall) lex_step();
      if (out_valid && !out_stall) check_word();
      pending <= due_results.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// stimulus, flow control and verdict for the character class lexer
`timescale 1ns / 1ps
module tb;
  import cdl_pkg::*;

  localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = 3'd5;
  localparam int SPARE_CODES = 3;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_AT_WORD = 100;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 16;

  // one input word with every field
  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [STATE_W-1:0] state_index;
    logic [RULE_W-1:0]  rule_index;
    logic [WORD_W-1:0]  word_index;
    logic [CLASS_W-1:0] class_word;
    logic [STATE_W-1:0] target_state;
    logic               invert;
    logic               rule_used;
    logic               is_final;
    logic [TOKEN_W-1:0] token;
    logic [CHAR_W-1:0]  character;
  } lex_item_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [FUNC_W-1:0]  func = '0;
  logic [STATE_W-1:0] state_index = '0;
  logic [RULE_W-1:0]  rule_index = '0;
  logic [WORD_W-1:0]  word_index = '0;
  logic [CLASS_W-1:0] class_word = '0;
  logic [STATE_W-1:0] target_state = '0;
  logic               invert = 1'b0;
  logic               rule_used = 1'b0;
  logic               is_final = 1'b0;
  logic [TOKEN_W-1:0] token = '0;
  logic [CHAR_W-1:0]  character = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               dead;
  logic [STATE_W-1:0] next_state;
  logic               accepting;
  logic [TOKEN_W-1:0] token_res;

  int errors;
  int pending;
  int n_words;
  int n_dead;
  int n_accepting;

  int n_items = 0;
  int n_spare = 0;
  int words_taken = 0;
  int stall_left = 0;

  // class words written so far per rule slot, so no scan reads an unwritten one
  logic [3:0] words_done [DEF_STATES*DEF_RULES] = '{default: '0};

  always #1 clk = ~clk;

  char_class_dfa_lexer DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .state_index  (state_index),
    .rule_index   (rule_index),
    .word_index   (word_index),
    .class_word   (class_word),
    .target_state (target_state),
    .invert       (invert),
    .rule_used    (rule_used),
    .is_final     (is_final),
    .token        (token),
    .character    (character),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .dead         (dead),
    .next_state   (next_state),
    .accepting    (accepting),
    .token_res    (token_res)
  );

  lexer_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .state_index  (state_index),
    .rule_index   (rule_index),
    .word_index   (word_index),
    .class_word   (class_word),
    .target_state (target_state),
    .invert       (invert),
    .rule_used    (rule_used),
    .is_final     (is_final),
    .token        (token),
    .character    (character),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .dead         (dead),
    .next_state   (next_state),
    .accepting    (accepting),
    .token_res    (token_res),
    .errors       (errors),
    .pending      (pending),
    .n_words      (n_words),
    .n_dead       (n_dead),
    .n_accepting  (n_accepting)
  );

  // result side: random hold-off per word, quiet stretches, one long hold
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        words_taken++;
        if (words_taken == HOLD_AT_WORD) stall_left = HOLD_CYCLES;
        else if ((words_taken / 64) % 4 == 3) stall_left = 0;
        else stall_left = $urandom_range(0, 7);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic lex_item_t noise_item();
    lex_item_t it;
    it.func         = 3'($urandom_range(0, 7));
    it.state_index  = 4'($urandom);
    it.rule_index   = 3'($urandom);
    it.word_index   = 2'($urandom);
    it.class_word   = {$urandom, $urandom};
    it.target_state = 4'($urandom);
    it.invert       = 1'($urandom);
    it.rule_used    = 1'($urandom);
    it.is_final     = 1'($urandom);
    it.token        = 8'($urandom);
    it.character    = 8'($urandom);
    return it;
  endfunction

  // empty, full, single character, sparse or dense class words
  function automatic logic [CLASS_W-1:0] rand_class();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      3: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // a handful of states get most of the traffic so runs walk programmed paths
  function automatic logic [STATE_W-1:0] pick_state();
    if ($urandom_range(0, 3) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, 5));
  endfunction

  // offer one word after a random gap and wait for it to be taken
  task automatic offer(lex_item_t it);
    int gap;
    int slot;
    slot = int'(it.state_index) * DEF_RULES + int'(it.rule_index);
    if (it.func == FN_RULE && words_done[slot] != 4'hF) it.rule_used = 1'b0;
    if (it.func == FN_CLASS) words_done[slot][it.word_index] = 1'b1;
    gap = ((n_items / 50) % 4 == 3) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    func         <= it.func;
    state_index  <= it.state_index;
    rule_index   <= it.rule_index;
    word_index   <= it.word_index;
    class_word   <= it.class_word;
    target_state <= it.target_state;
    invert       <= it.invert;
    rule_used    <= it.rule_used;
    is_final     <= it.is_final;
    token        <= it.token;
    character    <= it.character;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (it.func <= FN_CHAR) n_items++;
    else n_spare++;
  endtask

  task automatic put_class(logic [STATE_W-1:0] s, logic [RULE_W-1:0] r,
                           logic [WORD_W-1:0] w, logic [CLASS_W-1:0] bits);
    lex_item_t it;
    it = noise_item();
    it.func        = FN_CLASS;
    it.state_index = s;
    it.rule_index  = r;
    it.word_index  = w;
    it.class_word  = bits;
    offer(it);
  endtask

  task automatic put_rule(logic [STATE_W-1:0] s, logic [RULE_W-1:0] r, logic used,
                          logic inv, logic [STATE_W-1:0] tgt);
    lex_item_t it;
    it = noise_item();
    it.func         = FN_RULE;
    it.state_index  = s;
    it.rule_index   = r;
    it.rule_used    = used;
    it.invert       = inv;
    it.target_state = tgt;
    offer(it);
  endtask

  task automatic put_attr(logic [STATE_W-1:0] s, logic fin, logic [TOKEN_W-1:0] tok);
    lex_item_t it;
    it = noise_item();
    it.func        = FN_ATTR;
    it.state_index = s;
    it.is_final    = fin;
    it.token       = tok;
    offer(it);
  endtask

  task automatic restart(logic [STATE_W-1:0] s);
    lex_item_t it;
    it = noise_item();
    it.func        = FN_RESTART;
    it.state_index = s;
    offer(it);
  endtask

  task automatic feed(logic [CHAR_W-1:0] ch);
    lex_item_t it;
    it = noise_item();
    it.func      = FN_CHAR;
    it.character = ch;
    offer(it);
  endtask

  // stimulus and verdict
  initial begin
    lex_item_t          it;
    logic [STATE_W-1:0] s;
    logic [RULE_W-1:0]  r;
    int                 pick;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty tables: the first character kills the automaton, the next keeps it dead
    feed(8'h61);
    feed(8'h61);
    restart(4'd0);
    put_attr(4'd15, 1'b1, 8'hFF);
    put_attr(4'd1, 1'b1, 8'h41);
    // state 0: slot 0 takes 'a' and the top quarter to state 1
    put_class(4'd0, 3'd0, 2'd0, '0);
    put_class(4'd0, 3'd0, 2'd1, 64'd1 << 33);
    put_class(4'd0, 3'd0, 2'd2, '0);
    put_class(4'd0, 3'd0, 2'd3, '1);
    put_rule(4'd0, 3'd0, 1'b1, 1'b0, 4'd1);
    // state 0: last slot is an inverted empty class, a catch-all to state 15
    for (int w = 0; w < 4; w++) put_class(4'd0, 3'd7, 2'(w), '0);
    put_rule(4'd0, 3'd7, 1'b1, 1'b1, 4'd15);
    restart(4'd0);
    feed(8'h61);
    feed(8'hFF);
    restart(4'd0);
    feed(8'hFF);
    restart(4'd0);
    feed(8'h00);
    feed(8'h80);
    // codes with no function
    for (int k = 0; k < SPARE_CODES; k++) begin
      it = noise_item();
      it.func = FN_SPARE_FIRST + 3'(k);
      offer(it);
    end

    // random mix of table builds, restart-and-run strings and noise
    while (n_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 6) begin
        s = pick_state();
        if ($urandom_range(0, 1) == 1) put_attr(s, 1'($urandom), 8'($urandom));
        repeat ($urandom_range(1, 2)) begin
          r = 3'($urandom);
          for (int w = 0; w < 4; w++) put_class(s, r, 2'(w), rand_class());
          put_rule(s, r, 1'($urandom_range(0, 7) != 0), 1'($urandom), pick_state());
        end
      end else if (pick < 17) begin
        restart(pick_state());
        repeat ($urandom_range(1, 8)) feed(8'($urandom));
      end else begin
        offer(noise_item());
      end
    end
    in_valid <= 1'b0;

    // drain
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("char_class_dfa_lexer: %0d items and %0d spare codes sent, %0d result words checked",
             n_items, n_spare, n_words);
    $display("char_class_dfa_lexer: %0d dead and %0d accepting results, one %0d-cycle output hold",
             n_dead, n_accepting, HOLD_CYCLES);
    if (errors == 0 && pending == 0) begin
      $display("** char_class_dfa_lexer: PASSED **");
    end else begin
      $display("** char_class_dfa_lexer: FAILED **");
    end
    $finish;
  end

  // hard stop
  initial begin
    #200_000;
    $display("char_class_dfa_lexer: timeout with %0d words outstanding", pending);
    $display("** char_class_dfa_lexer: FAILED **");
    $finish;
  end

endmodule
